[rtl/modular_exponentiation_64_core_assert.svh]
// Assertion macros shared by the modular exponentiation RTL
`ifndef MODULAR_EXPONENTIATION_64_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_64_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define MX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define MX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/modexp_pkg.sv]
// Package: shared constants and sequencer state type for modular exponentiation
package modexp_pkg;

    // Width of every payload and configuration port
    localparam int FIELD_BITS = 64;

    // Default working width of the datapath
    localparam int WORD_BITS_DEFAULT = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DISPATCH,
        ST_MUL,
        ST_SQR
    } state_t;

endpackage

[rtl/modexp_mulmod.sv]
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle
module modexp_mulmod #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] addend,
    input  logic [WORD_BITS-1:0] multiplier,
    input  logic [WORD_BITS-1:0] modulus,
    output logic                 done,
    output logic [WORD_BITS-1:0] product
);
    import modexp_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int EXT_W = WORD_BITS + 2;

    logic                 running_reg, running_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] addend_reg, addend_next;
    logic [WORD_BITS-1:0] mplr_reg, mplr_next;

    logic [EXT_W-1:0]     sum_ext;
    logic [EXT_W-1:0]     mod1_ext;
    logic [EXT_W-1:0]     mod2_ext;
    logic [EXT_W-1:0]     diff1;
    logic [EXT_W-1:0]     diff2;
    logic [WORD_BITS-1:0] step_val;

    // One step: 2*acc + bit*addend (< 3m), then take off m or 2m.
    // A zero modulus means plain wraparound at the word width.
    always_comb
    begin
        sum_ext  = {2'b00, acc_reg} + {2'b00, acc_reg}
                 + (mplr_reg[WORD_BITS-1] ? {2'b00, addend_reg} : '0);
        mod1_ext = {2'b00, modulus};
        mod2_ext = {1'b0, modulus, 1'b0};
        diff1    = sum_ext - mod1_ext;
        diff2    = sum_ext - mod2_ext;
        if (modulus == '0)
        begin
            step_val = sum_ext[WORD_BITS-1:0];
        end
        else if (sum_ext >= mod2_ext)
        begin
            step_val = diff2[WORD_BITS-1:0];
        end
        else if (sum_ext >= mod1_ext)
        begin
            step_val = diff1[WORD_BITS-1:0];
        end
        else
        begin
            step_val = sum_ext[WORD_BITS-1:0];
        end
    end

    // Step control: load on start, then one bit per cycle, MSB first
    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        acc_next     = acc_reg;
        addend_next  = addend_reg;
        mplr_next    = mplr_reg;
        if (start)
        begin
            running_next = 1'b1;
            count_next   = CNT_W'(WORD_BITS - 1);
            acc_next     = '0;
            addend_next  = addend;
            mplr_next    = multiplier;
        end
        else if (running_reg)
        begin
            acc_next  = step_val;
            mplr_next = {mplr_reg[WORD_BITS-2:0], 1'b0};
            if (count_reg == '0)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        mplr_reg   <= mplr_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/modular_exponentiation_64_core.sv]
// Top level: modular exponentiation by right-to-left square-and-multiply
//
//  channel   ports                      handshake
//  -------   -------------------------  -----------------------------------
//  request   base_value, power          taken when start && !busy
//  result    residue                    valid for one cycle with done
//  config    modulus                    written when modulus_we
//
// The base is first folded below the modulus by one multiplier pass. Each
// exponent bit then costs a dispatch and a squaring, plus a dispatch and a
// multiply of the same length when it is set; the squaring after the top set
// bit is skipped. Reset sets the modulus to 1; results cannot be stalled.
module modular_exponentiation_64_core #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [modexp_pkg::FIELD_BITS-1:0] base_value,
    input  logic [modexp_pkg::FIELD_BITS-1:0] power,
    output logic                            done,
    output logic [modexp_pkg::FIELD_BITS-1:0] residue,
    input  logic                            modulus_we,
    input  logic [modexp_pkg::FIELD_BITS-1:0] modulus
);
    import modexp_pkg::*;

    state_t                state_reg, state_next;
    logic [FIELD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0]  base_reg, base_next;
    logic [WORD_BITS-1:0]  exp_reg, exp_next;
    logic [WORD_BITS-1:0]  r_reg, r_next;
    logic [FIELD_BITS-1:0] residue_reg, residue_next;
    logic                  done_reg, done_next;

    logic [WORD_BITS-1:0]  mod_w;
    logic [WORD_BITS-1:0]  one_mod;
    logic                  unit_start;
    logic [WORD_BITS-1:0]  unit_addend;
    logic [WORD_BITS-1:0]  unit_mplr;
    logic                  unit_done;
    logic [WORD_BITS-1:0]  unit_product;

    assign mod_w   = modulus_reg[WORD_BITS-1:0];
    // 1 reduced by the modulus, used to fold the base below the modulus
    assign one_mod = (mod_w == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

    // Shared modular multiplier
    modexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (unit_start),
        .addend     (unit_addend),
        .multiplier (unit_mplr),
        .modulus    (mod_w),
        .done       (unit_done),
        .product    (unit_product)
    );

    // Sequencer: next state and unit commands
    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        r_next       = r_reg;
        residue_next = residue_reg;
        done_next    = 1'b0;
        unit_start   = 1'b0;
        unit_addend  = base_reg;
        unit_mplr    = base_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    exp_next    = power[WORD_BITS-1:0];
                    r_next      = WORD_BITS'(1);
                    unit_start  = 1'b1;
                    unit_addend = one_mod;
                    unit_mplr   = base_value[WORD_BITS-1:0];
                    state_next  = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (unit_done)
                begin
                    base_next  = unit_product;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (exp_reg == '0)
                begin
                    // r is left at 1 unreduced when the exponent is zero
                    residue_next = FIELD_BITS'(r_reg);
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (exp_reg[0])
                begin
                    unit_start = 1'b1;
                    unit_mplr  = r_reg;
                    state_next = ST_MUL;
                end
                else
                begin
                    unit_start = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (unit_done)
                begin
                    r_next     = unit_product;
                    exp_next   = {exp_reg[WORD_BITS-1:1], 1'b0};
                    state_next = ST_DISPATCH;
                end
            end
            ST_SQR:
            begin
                if (unit_done)
                begin
                    base_next  = unit_product;
                    exp_next   = {1'b0, exp_reg[WORD_BITS-1:1]};
                    state_next = ST_DISPATCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            modulus_reg <= FIELD_BITS'(1);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        r_reg       <= r_next;
        residue_reg <= residue_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign residue = residue_reg;

    // Checks
`include "modular_exponentiation_64_core_assert.svh"

    `MX_ASSERT_NEXT(a_req_busy, start && !busy, busy, "accepted request did not raise busy")
    `MX_ASSERT_NEXT(a_done_src, state_reg == ST_DISPATCH && exp_reg == '0, done && !busy, "missing result strobe")
    `MX_ASSERT_NOW(a_unit_done, unit_done, state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR, "multiplier finished outside a multiply state")
    `MX_ASSERT_NOW(a_reduced, done && residue != FIELD_BITS'(1) && mod_w != '0, residue < FIELD_BITS'(mod_w), "result not reduced")

endmodule

[tb/modular_exponentiation_64_core_tb.sv]
// Self-checking testbench for the 64-bit modular exponentiation core
`timescale 1ns / 1ps

module modular_exponentiation_64_core_tb;

    localparam int W = modexp_pkg::FIELD_BITS;
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    // Largest 64-bit prime
    localparam logic [W-1:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam int RANDOM_PHASES = 6;
    localparam int REQS_PER_PHASE = 13;

    typedef struct packed {
        logic [W-1:0] base;
        logic [W-1:0] exponent;
    } modexp_req_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [W-1:0] base_value = '0;
    logic [W-1:0] power = '0;
    logic         done;
    logic [W-1:0] residue;
    logic         modulus_we = 1'b0;
    logic [W-1:0] modulus = '0;

    modexp_req_t  pending_requests[$];
    logic [W-1:0] expected_residues[$];
    logic [W-1:0] modulus_copy;
    modexp_req_t  next_req;
    int unsigned  gap_left;
    int unsigned  burst_left;
    int unsigned  n_fail = 0;

    modular_exponentiation_64_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .base_value (base_value),
        .power      (power),
        .done       (done),
        .residue    (residue),
        .modulus_we (modulus_we),
        .modulus    (modulus)
    );

    always #10 clk = ~clk;

    function automatic logic [W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Exact a*b mod m; a zero modulus means plain wrap at the word width
    function automatic logic [W-1:0] mulmod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] m);
        logic [2*W-1:0] prod;
        if (m == '0)
        begin
            prod = a * b;
            return prod[W-1:0];
        end
        prod = {{W{1'b0}}, a % m} * {{W{1'b0}}, b % m};
        prod = prod % {{W{1'b0}}, m};
        return prod[W-1:0];
    endfunction

    // Right-to-left square-and-multiply; the running result starts at 1 unreduced
    function automatic logic [W-1:0] modpow_residue(input logic [W-1:0] b,
                                                    input logic [W-1:0] e,
                                                    input logic [W-1:0] m);
        logic [W-1:0] acc;
        logic [W-1:0] sq;
        logic [W-1:0] rest;
        acc = 1;
        sq = b;
        rest = e;
        while (rest != '0)
        begin
            if (rest[0])
                acc = mulmod(acc, sq, m);
            sq = mulmod(sq, sq, m);
            rest = rest >> 1;
        end
        return acc;
    endfunction

    // Idle time between bursts: mostly none or short, sometimes past a whole request
    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 9)) inside
            [0:3]:   return 0;
            [4:7]:   return $urandom_range(1, 60);
            8:       return $urandom_range(100, 3000);
            default: return $urandom_range(3000, 9000);
        endcase
    endfunction

    function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
        case ($urandom_range(0, 4))
            0:       return rand64();
            1:       return W'($urandom_range(0, 20));
            2:       return ALL_ONES - W'($urandom_range(0, 20));
            3:       return m - W'($urandom_range(0, 3));
            default: return m + W'($urandom_range(0, 3));
        endcase
    endfunction

    // Mostly short exponents keep the run fast; full-width ones are random
    function automatic logic [W-1:0] pick_power();
        case ($urandom_range(0, 7)) inside
            0:       return '0;
            [1:2]:   return rand64();
            3:       return W'(1) << $urandom_range(0, W-1);
            default: return rand64() >> $urandom_range(W-16, W-1);
        endcase
    endfunction

    // Request driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            base_value <= '0;
            power <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (start && busy)
        begin
            // request still waiting to be taken
        end
        else if (gap_left != 0)
        begin
            start <= 1'b0;
            base_value <= rand64();
            power <= rand64();
            gap_left <= gap_left - 1;
        end
        else if (pending_requests.size() != 0)
        begin
            next_req = pending_requests.pop_front();
            start <= 1'b1;
            base_value <= next_req.base;
            power <= next_req.exponent;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 4);
                gap_left <= pick_gap();
            end
            else
                burst_left <= burst_left - 1;
        end
        else
        begin
            start <= 1'b0;
            base_value <= rand64();
            power <= rand64();
        end
    end

    // Result monitor: check strobed residues, then predict newly taken requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_copy <= 1;
        else
        begin
            if (done)
            begin
                if (expected_residues.size() == 0)
                begin
                    $display("%0t: residue %h with no request outstanding", $time, residue);
                    n_fail++;
                end
                else if (residue !== expected_residues[0])
                begin
                    $display("%0t: residue mismatch, expected %h actual %h",
                             $time, expected_residues[0], residue);
                    n_fail++;
                    void'(expected_residues.pop_front());
                end
                else
                    void'(expected_residues.pop_front());
            end
            if (start && !busy)
                expected_residues.insert(expected_residues.size(),
                                         modpow_residue(base_value, power, modulus_copy));
            if (modulus_we)
                modulus_copy <= modulus;
        end
    end

    task automatic add_req(input logic [W-1:0] b, input logic [W-1:0] e);
        modexp_req_t req_item;
        req_item.base = b;
        req_item.exponent = e;
        pending_requests.insert(pending_requests.size(), req_item);
    endtask

    // Wait until every request is taken and every residue has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || expected_residues.size() != 0);
    endtask

    task automatic set_modulus(input logic [W-1:0] value);
        wait_idle();
        @(posedge clk);
        modulus_we <= 1'b1;
        modulus <= value;
        @(posedge clk);
        modulus_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [W-1:0] m;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset modulus of 1: zero power stays 1, anything else reduces to 0
        add_req('0, '0);
        add_req(ALL_ONES, '0);
        add_req(5, 1);
        add_req(ALL_ONES, ALL_ONES);

        // Largest modulus, base equal to it, top exponent bit alone
        set_modulus(ALL_ONES);
        add_req(ALL_ONES, 1);
        add_req(ALL_ONES - 1, ALL_ONES);
        add_req(2, 63);
        add_req(2, 64);
        add_req('0, 5);
        add_req(1, ALL_ONES);
        add_req(3, 64'h8000_0000_0000_0000);

        // Zero modulus: arithmetic wraps at the word width
        set_modulus('0);
        add_req(3, 40);
        add_req(2, 64);
        add_req(ALL_ONES, 2);
        add_req(ALL_ONES, ALL_ONES);
        add_req('0, '0);

        // Prime modulus: Fermat check and bases above the modulus
        set_modulus(PRIME_64);
        add_req(2, PRIME_64 - 1);
        add_req(ALL_ONES, 3);
        add_req(123456789, 64'hAAAA_AAAA_AAAA_AAAA);

        // Smallest nontrivial modulus
        set_modulus(2);
        add_req(3, 5);
        add_req(4, 7);

        // Random phases, each under its own modulus
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       m = rand64() | 64'h8000_0000_0000_0000;
                1:       m = W'($urandom_range(2, 65535));
                2:       m = ALL_ONES;
                3:       m = '0;
                4:       m = {32'b0, $urandom} | 1;
                default: m = rand64();
            endcase
            set_modulus(m);
            for (int i = 0; i < REQS_PER_PHASE; i++)
                add_req(pick_base(m), pick_power());
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (n_fail == 0)
            $display("modular_exponentiation_64_core_tb OK");
        else
            $display("modular_exponentiation_64_core_tb NOT OK");
        $finish;
    end

    // Run limit, several times the slowest correct run
    initial
    begin
        #200_000_000;
        $display("modular_exponentiation_64_core_tb NOT OK");
        $finish;
    end

endmodule
